>>> rtl/core/trs_pkg.sv
// shared types and constants for the touch report serializer
package trs_pkg;

   localparam int unsigned POS_W    = 14;
   localparam int unsigned SIZE_W   = 14;
   localparam int unsigned COORD_W  = 16;
   localparam int unsigned FRAC_W   = 12;
   localparam int unsigned DIVD_W   = POS_W + FRAC_W;
   localparam int unsigned EVENT_W  = 2;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned BPOS_W   = 4;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned STEP_W   = 5;

   localparam logic [BYTE_W-1:0] SYNC_A         = 8'h55;
   localparam logic [BYTE_W-1:0] SYNC_B         = 8'h54;
   localparam logic [BYTE_W-1:0] CHECK_SEED     = 8'hAA;
   localparam logic [BYTE_W-1:0] STATUS_PRESS   = 8'h81;
   localparam logic [BYTE_W-1:0] STATUS_MOTION  = 8'h82;
   localparam logic [BYTE_W-1:0] STATUS_RELEASE = 8'h84;
   localparam logic [BYTE_W-1:0] STATUS_NONE    = 8'h00;

   localparam logic [SIZE_W-1:0] WIDTH_RESET  = 14'd640;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = 14'd480;

   localparam logic [BPOS_W-1:0] BPOS_LAST = 4'd9;

   localparam logic [STEP_W-1:0] DIV_LAST_STEP = STEP_W'(DIVD_W - 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      KIND_EVENT = 1'b0,
      KIND_READ  = 1'b1
   } kind_type;

   typedef enum logic [EVENT_W-1:0] {
      EV_PRESS   = 2'd0,
      EV_RELEASE = 2'd1,
      EV_MOTION  = 2'd2,
      EV_OTHER   = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      MODE_NONE     = 2'd0,
      MODE_START    = 2'd1,
      MODE_TOUCHING = 2'd2,
      MODE_END      = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_X,
      ST_DIV_Y
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

>>> rtl/core/trs_if.sv
// request, response and register write channels of the touch report serializer
interface trs_req_if;
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic [trs_pkg::POS_W-1:0]     pos_x;
   logic [trs_pkg::POS_W-1:0]     pos_y;
   logic [trs_pkg::EVENT_W-1:0]   event_kind;

   modport source (output valid, kind, pos_x, pos_y, event_kind, input ready);
   modport sink   (input valid, kind, pos_x, pos_y, event_kind, output ready);
endinterface

interface trs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [trs_pkg::BYTE_W-1:0]    data_byte;
   logic                          byte_valid;

   modport source (output valid, data_byte, byte_valid, input ready);
   modport sink   (input valid, data_byte, byte_valid, output ready);
endinterface

interface trs_csr_if;
   logic                          valid;
   logic                          ready;
   logic [trs_pkg::CSR_IDX_W-1:0] index;
   logic [trs_pkg::SIZE_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/trs_div.sv
// bit-serial restoring divider with 16-bit saturated quotient
module trs_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [trs_pkg::DIVD_W-1:0]    dividend,
   input  logic [trs_pkg::SIZE_W-1:0]    divisor,
   output trs_pkg::div_stat_type         stat,
   output logic [trs_pkg::COORD_W-1:0]   quotient
);
   import trs_pkg::*;

   logic [DIVD_W-1:0] quo_ff, quo_in;
   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic [SIZE_W-1:0] dsr_ff, dsr_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [SIZE_W:0]   trial;
   logic [SIZE_W:0]   diff;
   logic              fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIVD_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      fits    = (trial >= {1'b0, dsr_ff});
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[DIVD_W-2:0], fits};
         rem_in  = fits ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == DIV_LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // upper quotient bits set means the scaled value is out of range
   assign quotient   = (|quo_ff[DIVD_W-1:COORD_W]) ? '1 : quo_ff[COORD_W-1:0];
   assign stat.busy  = busy_ff;
   assign stat.done  = done_ff;

endmodule

>>> rtl/core/touch_report_serializer.sv
// top level of the touch report serializer: sequencer, report state and byte output
// a read beat's response beat is registered and shows in the cycle after the read is taken
// a pointer event runs two 26-step passes of the shared bit-serial divider
// (x, then y) in turn; no request is taken while the divider runs
// back-to-back reads sustain one beat per cycle while the response side keeps up
// synchronous reset: sizes 640 by 480, status and coordinates zero, start mode, nothing pending
module touch_report_serializer (
   input  logic  clock,
   input  logic  reset,
   trs_req_if.sink   req_bus,
   trs_rsp_if.source rsp_bus,
   trs_csr_if.sink   csr_bus
);
   import trs_pkg::*;

   state_type state_ff, state_in;

   logic [SIZE_W-1:0]  width_ff, height_ff;
   logic [BYTE_W-1:0]  status_ff, status_in;
   logic [COORD_W-1:0] panel_x_ff, panel_x_in;
   logic [COORD_W-1:0] panel_y_ff, panel_y_in;
   mode_type           mode_ff, mode_in;
   logic [BPOS_W-1:0]  bpos_ff, bpos_in;
   logic               pending_ff, pending_in;
   logic [POS_W-1:0]   pos_y_ff, pos_y_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_data_ff, rsp_data_in;
   logic               rsp_bvalid_ff, rsp_bvalid_in;

   logic               req_take;
   logic               div_start;
   logic [DIVD_W-1:0]  div_dividend;
   logic [SIZE_W-1:0]  div_divisor;
   div_stat_type       div_stat;
   logic [COORD_W-1:0] div_quotient;

   logic [BPOS_W-1:0]  cur_pos;
   logic [BYTE_W-1:0]  sum_status;
   logic [BYTE_W-1:0]  check_byte;
   logic [BYTE_W-1:0]  read_byte;

   trs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quotient)
   );

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (csr_index_type'(csr_bus.index))
            CSR_WIDTH:  width_ff  <= csr_bus.data;
            CSR_HEIGHT: height_ff <= csr_bus.data;
            default:    width_ff  <= width_ff;
         endcase
      end
   end

   assign req_bus.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign req_take      = req_bus.valid && req_bus.ready;

   assign cur_pos = (bpos_ff > BPOS_LAST) ? '0 : bpos_ff;

   // touching mode rewrites the status before the checksum is formed
   assign sum_status = ((cur_pos == BPOS_LAST) && (mode_ff == MODE_TOUCHING)) ?
                       STATUS_MOTION : status_ff;
   assign check_byte = CHECK_SEED + SYNC_A + SYNC_B + sum_status
                     + panel_x_ff[7:0] + panel_x_ff[15:8]
                     + panel_y_ff[7:0] + panel_y_ff[15:8];

   always_comb begin
      case (cur_pos)
         4'd0:    read_byte = SYNC_A;
         4'd1:    read_byte = SYNC_B;
         4'd2:    read_byte = status_ff;
         4'd3:    read_byte = panel_x_ff[7:0];
         4'd4:    read_byte = panel_x_ff[15:8];
         4'd5:    read_byte = panel_y_ff[7:0];
         4'd6:    read_byte = panel_y_ff[15:8];
         4'd9:    read_byte = check_byte;
         default: read_byte = '0;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      status_in     = status_ff;
      panel_x_in    = panel_x_ff;
      panel_y_in    = panel_y_ff;
      mode_in       = mode_ff;
      bpos_in       = bpos_ff;
      pending_in    = pending_ff;
      pos_y_in      = pos_y_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_data_in   = rsp_data_ff;
      rsp_bvalid_in = rsp_bvalid_ff;
      div_start     = 1'b0;
      div_dividend  = {req_bus.pos_x, {FRAC_W{1'b0}}};
      div_divisor   = width_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (kind_type'(req_bus.kind) == KIND_EVENT) begin
                  div_start  = 1'b1;
                  pos_y_in   = req_bus.pos_y;
                  pending_in = 1'b1;
                  state_in   = ST_DIV_X;
                  case (event_type'(req_bus.event_kind))
                     EV_PRESS: begin
                        status_in = STATUS_PRESS;
                        mode_in   = MODE_START;
                     end
                     EV_RELEASE: begin
                        status_in = STATUS_RELEASE;
                        mode_in   = MODE_END;
                     end
                     EV_MOTION: begin
                        status_in = STATUS_MOTION;
                        mode_in   = MODE_TOUCHING;
                     end
                     default: status_in = STATUS_NONE;
                  endcase
               end else begin
                  rsp_valid_in = 1'b1;
                  if (!pending_ff) begin
                     rsp_data_in   = '0;
                     rsp_bvalid_in = 1'b0;
                  end else begin
                     rsp_data_in   = read_byte;
                     rsp_bvalid_in = 1'b1;
                     if (cur_pos == BPOS_LAST) begin
                        bpos_in = '0;
                        case (mode_ff)
                           MODE_START:    mode_in    = MODE_TOUCHING;
                           MODE_TOUCHING: status_in  = STATUS_MOTION;
                           MODE_END:      pending_in = 1'b0;
                           default:       mode_in    = mode_ff;
                        endcase
                     end else begin
                        bpos_in = cur_pos + 1'b1;
                     end
                  end
               end
            end
         end
         ST_DIV_X: begin
            if (div_stat.done) begin
               panel_x_in   = div_quotient;
               div_start    = 1'b1;
               div_dividend = {pos_y_ff, {FRAC_W{1'b0}}};
               div_divisor  = height_ff;
               state_in     = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            if (div_stat.done) begin
               panel_y_in = div_quotient;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      pos_y_ff      <= pos_y_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_bvalid_ff <= rsp_bvalid_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         status_ff    <= STATUS_NONE;
         panel_x_ff   <= '0;
         panel_y_ff   <= '0;
         mode_ff      <= MODE_START;
         bpos_ff      <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         panel_x_ff   <= panel_x_in;
         panel_y_ff   <= panel_y_in;
         mode_ff      <= mode_in;
         bpos_ff      <= bpos_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.data_byte  = rsp_data_ff;
   assign rsp_bus.byte_valid = rsp_bvalid_ff;

endmodule
